### src/cobs_crc_frame_receiver_macros.svh
// Assertion macros shared by the frame receiver modules.
`ifndef COBS_CRC_FRAME_RECEIVER_MACROS_SVH
`define COBS_CRC_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, inactive during reset.
`define CCFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccfr assertion failed");

// Next-cycle implication, inactive during reset.
`define CCFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccfr assertion failed");

`endif

### src/ccfr_pkg.sv
package ccfr_pkg;

   // event codes on the input channel
   localparam logic [1:0] FUNC_DATA  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_ERROR = 2'd2;

   // register indexes of the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_CRC_POLY  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_ADDR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BCAST     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PROMISC   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN   = 3'd4;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_LEN_W = 11;
   // wide enough for any frame position or limit compare
   localparam int CMP_W = 17;

   localparam logic [15:0]          POLY_RESET   = 16'h8005;
   localparam logic [7:0]           BCAST_RESET  = 8'hFF;
   localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 11'd1024;

   typedef enum logic [3:0] {
      KIND_CONSUMED   = 4'd0,
      KIND_BYTE_OUT   = 4'd1,
      KIND_SYNCED     = 4'd2,
      KIND_ACCEPTED   = 4'd3,
      KIND_LINE_ERROR = 4'd4,
      KIND_UNSYNCED   = 4'd5,
      KIND_ZERO_START = 4'd6,
      KIND_MISMATCH   = 4'd7,
      KIND_OVERFLOW   = 4'd8,
      KIND_TOO_SHORT  = 4'd9,
      KIND_CRC_BAD    = 4'd10,
      KIND_FILTERED   = 4'd11
   } kind_type;

   typedef struct packed {
      logic [15:0]          crc_poly;
      logic [7:0]           own_addr;
      logic [7:0]           broadcast_addr;
      logic                 promiscuous;
      logic [MAX_LEN_W-1:0] max_len;
   } cfg_type;

   typedef struct packed {
      logic feed;    // fold the released byte into the checksum
      logic clear;   // restart the checksum
   } crc_ctl_type;

   typedef struct packed {
      kind_type    kind;
      logic        data_valid;
      logic [7:0]  out_byte;
      logic [9:0]  byte_index;
      logic [7:0]  frame_addr;
      logic [7:0]  frame_cmd;
      logic [9:0]  payload_len;
      logic [15:0] drop_count;
      logic [15:0] accept_count;
   } rsp_type;

endpackage

### src/cobs_crc_frame_receiver.sv
// COBS frame receiver with CRC16 check and address filter.
// req_ channel: one line event per transfer (req_func: data byte, start
//   pattern or line error; req_line_byte for data). A transfer happens when
//   req_valid is high and req_stall is low.
// rsp_ channel: exactly one result per event, in order, same handshake with
//   rsp_stall driven by the receiver. Frame bytes but the CRC come out two bytes
//   late as byte-out results; the frame end gives the outcome with address,
//   command and payload length. Drop and accept counters ride on every result.
// csr_ channel: register writes (index, data), csr_ready is always high.
//   Write only while no event is in flight.
// An event passes the input register, then the result register, before
//   rsp_valid rises; a receiver stall can hold it in between.
//   Throughput: one event per cycle while rsp_stall is low; the decode and
//   the byte step of the checksum fit between the two registers.
// Receiver stall: the result register holds, the input register takes one more
//   event if it is empty, then req_stall rises until rsp_stall drops.
// Reset: registers back to defaults, receiver out of sync, counters zero,
//   both pipeline registers empty.
`include "cobs_crc_frame_receiver_macros.svh"

module cobs_crc_frame_receiver #(
   parameter int MAX_FRAME = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // event input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_func,
   input  logic [7:0]                        req_line_byte,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [3:0]                        rsp_kind,
   output logic                              rsp_data_valid,
   output logic [7:0]                        rsp_out_byte,
   output logic [9:0]                        rsp_byte_index,
   output logic [7:0]                        rsp_frame_addr,
   output logic [7:0]                        rsp_frame_cmd,
   output logic [9:0]                        rsp_payload_len,
   output logic [15:0]                       rsp_drop_count,
   output logic [15:0]                       rsp_accept_count,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccfr_pkg::CSR_DATA_W-1:0]   csr_data
);

   ccfr_pkg::cfg_type     cfg;
   ccfr_pkg::crc_ctl_type crc_ctl;
   ccfr_pkg::rsp_type     result;
   ccfr_pkg::rsp_type     rsp_ff;
   logic [15:0]           crc_final;
   logic [7:0]            next_rel;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_func_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_take;
   logic       move;     // input register item goes through decode

   assign move      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   ccfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ccfr_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .poly      (cfg.crc_poly),
      .ctl       (crc_ctl),
      .next_rel  (next_rel),
      .crc_final (crc_final)
   );

   ccfr_core #(
      .MAX_FRAME (MAX_FRAME)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .move      (move),
      .func      (in_func_ff),
      .line_byte (in_byte_ff),
      .crc_final (crc_final),
      .crc_ctl   (crc_ctl),
      .next_rel  (next_rel),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_line_byte;
      end
      if (move) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_ff.kind;
   assign rsp_data_valid   = rsp_ff.data_valid;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_byte_index   = rsp_ff.byte_index;
   assign rsp_frame_addr   = rsp_ff.frame_addr;
   assign rsp_frame_cmd    = rsp_ff.frame_cmd;
   assign rsp_payload_len  = rsp_ff.payload_len;
   assign rsp_drop_count   = rsp_ff.drop_count;
   assign rsp_accept_count = rsp_ff.accept_count;

   // a held event is never lost or overwritten
   `CCFR_ASSERT_NEXT(a_in_held, clock, reset, in_valid_ff && !move, in_valid_ff)
   // every decoded event lands in the result register
   `CCFR_ASSERT_NEXT(a_move_lands, clock, reset, move, rsp_valid_ff)

endmodule

### src/ccfr_csr.sv
module ccfr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ccfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccfr_pkg::CSR_DATA_W-1:0]   csr_data,
   output ccfr_pkg::cfg_type                 cfg
);

   ccfr_pkg::cfg_type cfg_ff;
   ccfr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            ccfr_pkg::CSR_CRC_POLY: cfg_in.crc_poly       = csr_data[15:0];
            ccfr_pkg::CSR_OWN_ADDR: cfg_in.own_addr       = csr_data[7:0];
            ccfr_pkg::CSR_BCAST:    cfg_in.broadcast_addr = csr_data[7:0];
            ccfr_pkg::CSR_PROMISC:  cfg_in.promiscuous    = csr_data[0];
            ccfr_pkg::CSR_MAX_LEN:  cfg_in.max_len = csr_data[ccfr_pkg::MAX_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_poly       <= ccfr_pkg::POLY_RESET;
         cfg_ff.own_addr       <= 8'h00;
         cfg_ff.broadcast_addr <= ccfr_pkg::BCAST_RESET;
         cfg_ff.promiscuous    <= 1'b0;
         cfg_ff.max_len        <= ccfr_pkg::MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### src/ccfr_crc.sv
// Augmented LSB-first CRC16. crc_ff is the running checksum; z_ff holds it
// advanced by eight zero bits and f_ff holds the next released byte shifted
// into a zero register, so a byte step is one xor plus eight shift stages.
module ccfr_crc (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           poly,
   input  ccfr_pkg::crc_ctl_type ctl,
   input  logic [7:0]            next_rel,   // high delay byte after this cycle
   output logic [15:0]           crc_final   // finished and bit-reversed
);

   logic [15:0] crc_ff, crc_in;
   logic [15:0] z_ff, z_in;
   logic [15:0] f_ff, f_in;
   logic [15:0] z16;

   function automatic logic [15:0] feed8(input logic [15:0] r, input logic [7:0] v,
                                         input logic [15:0] p);
      logic [15:0] acc;
      logic        top;
      acc = r;
      for (int i = 0; i < 8; i++) begin
         top = acc[15];
         acc = {acc[14:0], v[i]};
         if (top) acc = acc ^ p;
      end
      return acc;
   endfunction

   always_comb begin
      if (ctl.clear)     crc_in = 16'h0000;
      else if (ctl.feed) crc_in = z_ff ^ f_ff;
      else               crc_in = crc_ff;
      z_in = feed8(crc_in, 8'h00, poly);
      f_in = feed8(16'h0000, next_rel, poly);
   end

   // sixteen zero bits in total, then mirror
   assign z16 = feed8(z_ff, 8'h00, poly);

   always_comb begin
      for (int i = 0; i < 16; i++) crc_final[i] = z16[15-i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 16'h0000;
         z_ff   <= 16'h0000;
         f_ff   <= 16'h0000;
      end else begin
         crc_ff <= crc_in;
         z_ff   <= z_in;
         f_ff   <= f_in;
      end
   end

endmodule

### src/ccfr_core.sv
`include "cobs_crc_frame_receiver_macros.svh"

// Sync tracking, COBS decode, byte delay line and end-of-frame checks.
module ccfr_core #(
   parameter int MAX_FRAME = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ccfr_pkg::cfg_type     cfg,
   input  logic                  move,
   input  logic [1:0]            func,
   input  logic [7:0]            line_byte,
   input  logic [15:0]           crc_final,
   output ccfr_pkg::crc_ctl_type crc_ctl,
   output logic [7:0]            next_rel,
   output ccfr_pkg::rsp_type     result
);

   localparam int LEN_TOP   = (1 << ccfr_pkg::MAX_LEN_W) - 1;
   localparam int LIMIT_CAP = (MAX_FRAME < LEN_TOP) ? MAX_FRAME : LEN_TOP;
   localparam int POS_W     = $clog2(LIMIT_CAP + 2);
   localparam int CW        = ccfr_pkg::CMP_W;

   logic             synced_ff, synced_in;
   logic [7:0]       code_ff, code_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      delay_ff, delay_in;
   logic [7:0]       addr_ff, addr_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [15:0]      drops_ff, drops_in;
   logic [15:0]      accepts_ff, accepts_in;

   logic             do_clear, do_drop, do_accept;
   logic [CW-1:0]    pos_w;        // frame_pos - 1
   logic [CW-1:0]    idx_w, plen_w;
   logic [7:0]       code_dec, val;
   logic             overflow, addr_ok;

   assign pos_w    = CW'(pos_ff) - CW'(1);
   assign idx_w    = pos_w - CW'(2);
   assign plen_w   = pos_w - CW'(4);
   assign code_dec = code_ff - 8'd1;
   assign val      = (code_dec == 8'd0) ? 8'd0 : line_byte;
   assign overflow = (pos_w >= CW'(cfg.max_len)) || (pos_w >= CW'(MAX_FRAME));
   assign addr_ok  = (addr_ff == cfg.own_addr) || (addr_ff == cfg.broadcast_addr)
                     || cfg.promiscuous;

   always_comb begin
      synced_in    = synced_ff;
      code_in      = code_ff;
      pos_in       = pos_ff;
      delay_in     = delay_ff;
      addr_in      = addr_ff;
      cmd_in       = cmd_ff;
      do_clear     = 1'b0;
      do_drop      = 1'b0;
      do_accept    = 1'b0;
      crc_ctl.feed = 1'b0;
      result       = '0;
      result.kind  = ccfr_pkg::KIND_CONSUMED;

      if (move) begin
         case (func)
            ccfr_pkg::FUNC_ERROR: begin
               do_drop     = 1'b1;
               do_clear    = 1'b1;
               synced_in   = 1'b0;
               result.kind = ccfr_pkg::KIND_LINE_ERROR;
            end
            ccfr_pkg::FUNC_START: begin
               if (!synced_ff) begin
                  synced_in   = 1'b1;
                  do_clear    = 1'b1;
                  result.kind = ccfr_pkg::KIND_SYNCED;
               end
            end
            ccfr_pkg::FUNC_DATA: begin
               if (!synced_ff) begin
                  do_drop     = 1'b1;
                  do_clear    = 1'b1;
                  result.kind = ccfr_pkg::KIND_UNSYNCED;
               end else if (pos_ff == '0) begin
                  // first code byte of a frame
                  if (line_byte == 8'd0) begin
                     do_drop     = 1'b1;
                     do_clear    = 1'b1;
                     synced_in   = 1'b0;
                     result.kind = ccfr_pkg::KIND_ZERO_START;
                  end else begin
                     code_in = line_byte;
                     pos_in  = POS_W'(1);
                  end
               end else if (line_byte == 8'd0) begin
                  // closing zero
                  do_clear = 1'b1;
                  if (code_ff != 8'd1) begin
                     do_drop     = 1'b1;
                     synced_in   = 1'b0;
                     result.kind = ccfr_pkg::KIND_MISMATCH;
                  end else if (pos_w < CW'(4)) begin
                     result.kind = ccfr_pkg::KIND_TOO_SHORT;
                  end else begin
                     result.frame_addr  = addr_ff;
                     result.frame_cmd   = cmd_ff;
                     result.payload_len = plen_w[9:0];
                     if (crc_final != delay_ff) begin
                        result.kind = ccfr_pkg::KIND_CRC_BAD;
                     end else if (!addr_ok) begin
                        result.kind = ccfr_pkg::KIND_FILTERED;
                     end else begin
                        do_accept   = 1'b1;
                        result.kind = ccfr_pkg::KIND_ACCEPTED;
                     end
                  end
               end else begin
                  // code expiry decodes a zero and the byte is the next code
                  code_in = (code_dec == 8'd0) ? line_byte : code_dec;
                  if (overflow) begin
                     do_drop     = 1'b1;
                     do_clear    = 1'b1;
                     synced_in   = 1'b0;
                     result.kind = ccfr_pkg::KIND_OVERFLOW;
                  end else begin
                     if (pos_ff == POS_W'(1)) addr_in = val;
                     if (pos_ff == POS_W'(2)) cmd_in  = val;
                     if (pos_w >= CW'(2)) begin
                        crc_ctl.feed      = 1'b1;
                        result.kind       = ccfr_pkg::KIND_BYTE_OUT;
                        result.data_valid = 1'b1;
                        result.out_byte   = delay_ff[15:8];
                        result.byte_index = idx_w[9:0];
                     end
                     delay_in = {delay_ff[7:0], val};
                     pos_in   = pos_ff + POS_W'(1);
                  end
               end
            end
            default: ;
         endcase
      end

      if (do_clear) begin
         code_in  = 8'd0;
         pos_in   = '0;
         delay_in = 16'h0000;
         addr_in  = 8'd0;
         cmd_in   = 8'd0;
      end
      crc_ctl.clear = do_clear;

      drops_in   = (do_drop && drops_ff != 16'hFFFF) ? drops_ff + 16'd1 : drops_ff;
      accepts_in = (do_accept && accepts_ff != 16'hFFFF) ? accepts_ff + 16'd1
                                                          : accepts_ff;
      result.drop_count   = drops_in;
      result.accept_count = accepts_in;
   end

   assign next_rel = delay_in[15:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff  <= 1'b0;
         code_ff    <= 8'd0;
         pos_ff     <= '0;
         delay_ff   <= 16'h0000;
         addr_ff    <= 8'd0;
         cmd_ff     <= 8'd0;
         drops_ff   <= 16'd0;
         accepts_ff <= 16'd0;
      end else begin
         synced_ff  <= synced_in;
         code_ff    <= code_in;
         pos_ff     <= pos_in;
         delay_ff   <= delay_in;
         addr_ff    <= addr_in;
         cmd_ff     <= cmd_in;
         drops_ff   <= drops_in;
         accepts_ff <= accepts_in;
      end
   end

   // out of sync the decoder always sits cleared
   `CCFR_ASSERT_NOW(a_unsynced_clear, clock, reset, !synced_ff,
                    pos_ff == '0 && code_ff == 8'd0 && delay_ff == 16'h0000)
   `CCFR_ASSERT_NEXT(a_accept_count, clock, reset,
                     move && result.kind == ccfr_pkg::KIND_ACCEPTED,
                     accepts_ff == $past(accepts_ff) + 16'd1 || accepts_ff == 16'hFFFF)

endmodule
